>>> design/rx_ring_buffer_line_reader_unit_assert.svh
// Assertion macros used by the receive buffer control module.
`ifndef RX_RING_BUFFER_LINE_READER_UNIT_ASSERT_SVH
`define RX_RING_BUFFER_LINE_READER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBL_ASSERT_IMPL(lbl, clock, resetn, ante, cons, msg) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBL_ASSERT_NEXT(lbl, clock, resetn, ante, cons, msg) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rbl_pkg.sv
package rbl_pkg;

    localparam int RING_DEPTH = 32;
    localparam int LINE_DEPTH = 64;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int MAX_READ   = 64;
    localparam int LEN_W      = 7;
    localparam int OCC_W      = 5;
    localparam int BYTE_W     = 8;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [RING_AW-1:0] ring_ptr_t;
    typedef logic [LINE_AW-1:0] line_ptr_t;
    typedef logic [LEN_W-1:0]   len_t;

    localparam byte_t CH_ETX = 8'h03;
    localparam byte_t CH_LF  = 8'h0A;
    localparam byte_t CH_CR  = 8'h0D;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_RAW    = 2'd1,
        OP_EXPAND = 2'd2,
        OP_LINE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_PUSHED    = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_OVERWROTE = 3'd2,
        ST_DATA      = 3'd3,
        ST_NOTHING   = 3'd4,
        ST_LINE_BYTE = 3'd5,
        ST_NO_LINE   = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SINGLE,
        S_SCAN_PRIME,
        S_SCAN,
        S_EMIT_PRIME,
        S_EMIT,
        S_DRAIN_PRIME,
        S_DRAIN,
        S_SWALLOW,
        S_LINE_PRIME,
        S_LINE_EMIT
    } state_t;

    typedef struct packed {
        status_t          status;
        byte_t            data;
        logic             last;
        logic             line_complete;
        logic [OCC_W-1:0] occupancy;
    } result_t;

    function automatic ring_ptr_t ring_next(input ring_ptr_t p);
        return (p == ring_ptr_t'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Number of bytes held between read and write pointer.
    function automatic ring_ptr_t ring_count(input ring_ptr_t wp, input ring_ptr_t rp);
        logic [RING_AW:0] diff;
        diff = {1'b0, wp} - {1'b0, rp};
        if (wp < rp)
        begin
            diff = diff + (RING_AW + 1)'(RING_DEPTH);
        end
        return diff[RING_AW-1:0];
    endfunction

    function automatic logic is_delim(input byte_t b);
        return (b == CH_CR) || (b == CH_LF) || (b == CH_ETX);
    endfunction

endpackage

>>> design/rx_ring_buffer_line_reader_unit.sv
// Receive ring buffer with raw, CR-expanding and line reads. The ring holds up to 31
// bytes in a synchronous RAM; a line store RAM collects bytes for line reads. One
// request is worked on at a time; a push gives a single status result. A raw or
// expanding read that pops k bytes gives r results (r is k, or up to 2k when CRs
// are expanded). The ring RAM is walked twice: first one byte per cycle to count
// the bytes popped (every result reports the final occupancy), then one result per
// cycle, while the output is not stalled, to emit them. A line read drains the ring
// into the line store (delimiters are not stored), swallows the delimiters that
// follow, then delivers the line bytes. A stalled output holds the engine in place.
// There is no clearing pass after reset.
module rx_ring_buffer_line_reader_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] data_in,
    input  logic [6:0] read_length,
    input  logic       cfg_write_enable,
    input  logic       cfg_write_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [7:0] data_out,
    output logic       last,
    output logic       line_complete,
    output logic [4:0] occupancy
);

    logic               res_valid;
    logic               res_ready;
    rbl_pkg::result_t   res;
    rbl_pkg::result_t   out_res;
    logic               ring_we;
    rbl_pkg::ring_ptr_t ring_waddr;
    rbl_pkg::byte_t     ring_wdata;
    rbl_pkg::ring_ptr_t ring_raddr;
    rbl_pkg::byte_t     ring_rdata;
    logic               line_we;
    rbl_pkg::line_ptr_t line_waddr;
    rbl_pkg::byte_t     line_wdata;
    rbl_pkg::line_ptr_t line_raddr;
    rbl_pkg::byte_t     line_rdata;

    rbl_ram #(
        .DEPTH (rbl_pkg::RING_DEPTH),
        .WIDTH (rbl_pkg::BYTE_W)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    rbl_ram #(
        .DEPTH (rbl_pkg::LINE_DEPTH),
        .WIDTH (rbl_pkg::BYTE_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    rbl_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .data_in          (data_in),
        .read_length      (read_length),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .res_valid        (res_valid),
        .res              (res),
        .res_ready        (res_ready),
        .ring_we          (ring_we),
        .ring_waddr       (ring_waddr),
        .ring_wdata       (ring_wdata),
        .ring_raddr       (ring_raddr),
        .ring_rdata       (ring_rdata),
        .line_we          (line_we),
        .line_waddr       (line_waddr),
        .line_wdata       (line_wdata),
        .line_raddr       (line_raddr),
        .line_rdata       (line_rdata)
    );

    rbl_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign status        = out_res.status;
    assign data_out      = out_res.data;
    assign last          = out_res.last;
    assign line_complete = out_res.line_complete;
    assign occupancy     = out_res.occupancy;

endmodule

>>> design/rbl_ram.sv
module rbl_ram #(
    parameter int  DEPTH = 32,
    parameter int  WIDTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/rbl_ctrl.sv
`include "rx_ring_buffer_line_reader_unit_assert.svh"

module rbl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  rbl_pkg::byte_t      data_in,
    input  rbl_pkg::len_t       read_length,
    input  logic                cfg_write_enable,
    input  logic                cfg_write_data,
    output logic                res_valid,
    output rbl_pkg::result_t    res,
    input  logic                res_ready,
    output logic                ring_we,
    output rbl_pkg::ring_ptr_t  ring_waddr,
    output rbl_pkg::byte_t      ring_wdata,
    output rbl_pkg::ring_ptr_t  ring_raddr,
    input  rbl_pkg::byte_t      ring_rdata,
    output logic                line_we,
    output rbl_pkg::line_ptr_t  line_waddr,
    output rbl_pkg::byte_t      line_wdata,
    output rbl_pkg::line_ptr_t  line_raddr,
    input  rbl_pkg::byte_t      line_rdata
);

    rbl_pkg::state_t    state_reg, state_next;
    rbl_pkg::ring_ptr_t wp_reg, wp_next;
    rbl_pkg::ring_ptr_t rp_reg, rp_next;
    rbl_pkg::line_ptr_t line_len_reg, line_len_next;
    logic               line_deliv_reg, line_deliv_next;
    logic               ovw_reg, ovw_next;
    logic               lf_pend_reg, lf_pend_next;

    rbl_pkg::ring_ptr_t sp_reg, sp_next;
    rbl_pkg::line_ptr_t li_reg, li_next;
    rbl_pkg::op_t       op_reg, op_next;
    rbl_pkg::len_t      len_reg, len_next;
    rbl_pkg::len_t      n_reg, n_next;
    rbl_pkg::ring_ptr_t pops_reg, pops_next;
    rbl_pkg::ring_ptr_t ecnt_reg, ecnt_next;
    rbl_pkg::status_t   st_reg, st_next;
    logic               lc_reg, lc_next;

    rbl_pkg::op_t       op_in;
    rbl_pkg::len_t      len_clamped;
    rbl_pkg::ring_ptr_t count;
    rbl_pkg::ring_ptr_t wp_inc;
    rbl_pkg::ring_ptr_t sp_inc;
    rbl_pkg::len_t      n_inc;
    rbl_pkg::len_t      n_scan;
    rbl_pkg::ring_ptr_t pops_inc;
    logic [rbl_pkg::LINE_AW:0] li_inc;
    logic               in_fire;
    logic               res_fire;
    logic               full;
    logic               byte_delim;
    logic               empty_after;
    logic               expand;
    logic               scan_done;
    logic               emit_last;
    logic               line_last;
    logic               line_full;

    assign op_in       = rbl_pkg::op_t'(op);
    assign len_clamped = (read_length > rbl_pkg::len_t'(rbl_pkg::MAX_READ)) ?
                         rbl_pkg::len_t'(rbl_pkg::MAX_READ) : read_length;
    assign count       = rbl_pkg::ring_count(wp_reg, rp_reg);
    assign wp_inc      = rbl_pkg::ring_next(wp_reg);
    assign full        = (wp_inc == rp_reg);
    assign sp_inc      = rbl_pkg::ring_next(sp_reg);
    assign empty_after = (sp_inc == wp_reg);
    assign byte_delim  = rbl_pkg::is_delim(ring_rdata);
    assign in_ready    = (state_reg == rbl_pkg::S_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign res_fire    = res_valid && res_ready;
    assign n_inc       = n_reg + 1'b1;
    assign pops_inc    = pops_reg + 1'b1;
    assign line_full   = (line_len_reg == rbl_pkg::line_ptr_t'(rbl_pkg::LINE_DEPTH - 1));
    assign li_inc      = {1'b0, li_reg} + 1'b1;
    assign ring_raddr  = sp_next;
    assign line_raddr  = li_next;

    // A CR becomes CR LF only while a second output slot is left.
    assign expand    = (op_reg == rbl_pkg::OP_EXPAND) && (ring_rdata == rbl_pkg::CH_CR) &&
                       (n_inc < len_reg);
    assign n_scan    = expand ? n_reg + 2'd2 : n_inc;
    assign scan_done = (n_scan >= len_reg) || (pops_inc == count);
    assign emit_last = lf_pend_reg ? (ecnt_reg == pops_reg) :
                       (((ecnt_reg + 1'b1) == pops_reg) && !expand);
    assign line_last = (li_inc == {1'b0, line_len_reg}) ||
                       (32'(li_inc) == 32'(rbl_pkg::MAX_READ));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbl_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    case (op_in)
                        rbl_pkg::OP_PUSH:
                        begin
                            state_next = rbl_pkg::S_SINGLE;
                        end
                        rbl_pkg::OP_RAW, rbl_pkg::OP_EXPAND:
                        begin
                            if ((len_clamped == '0) || (count == '0))
                            begin
                                state_next = rbl_pkg::S_SINGLE;
                            end
                            else
                            begin
                                state_next = rbl_pkg::S_SCAN_PRIME;
                            end
                        end
                        default:
                        begin
                            if (line_deliv_reg || (count == '0))
                            begin
                                state_next = rbl_pkg::S_SINGLE;
                            end
                            else
                            begin
                                state_next = rbl_pkg::S_DRAIN_PRIME;
                            end
                        end
                    endcase
                end
            end
            rbl_pkg::S_SINGLE:
            begin
                if (res_fire)
                begin
                    state_next = rbl_pkg::S_IDLE;
                end
            end
            rbl_pkg::S_SCAN_PRIME:
            begin
                state_next = rbl_pkg::S_SCAN;
            end
            rbl_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = rbl_pkg::S_EMIT_PRIME;
                end
            end
            rbl_pkg::S_EMIT_PRIME:
            begin
                state_next = rbl_pkg::S_EMIT;
            end
            rbl_pkg::S_EMIT:
            begin
                if (res_fire && emit_last)
                begin
                    state_next = rbl_pkg::S_IDLE;
                end
            end
            rbl_pkg::S_DRAIN_PRIME:
            begin
                state_next = rbl_pkg::S_DRAIN;
            end
            rbl_pkg::S_DRAIN:
            begin
                if (byte_delim)
                begin
                    state_next = empty_after ? rbl_pkg::S_LINE_PRIME : rbl_pkg::S_SWALLOW;
                end
                else if (empty_after)
                begin
                    state_next = rbl_pkg::S_SINGLE;
                end
            end
            rbl_pkg::S_SWALLOW:
            begin
                if (!byte_delim || empty_after)
                begin
                    state_next = rbl_pkg::S_LINE_PRIME;
                end
            end
            rbl_pkg::S_LINE_PRIME:
            begin
                state_next = (line_len_reg == '0) ? rbl_pkg::S_SINGLE : rbl_pkg::S_LINE_EMIT;
            end
            rbl_pkg::S_LINE_EMIT:
            begin
                if (res_fire && line_last)
                begin
                    state_next = rbl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rbl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid  = 1'b0;
        res        = '0;
        ring_we    = in_fire && (op_in == rbl_pkg::OP_PUSH) && !(full && !ovw_reg);
        ring_waddr = wp_reg;
        ring_wdata = data_in;
        line_we    = (state_reg == rbl_pkg::S_DRAIN) && !byte_delim && !line_full;
        line_waddr = line_len_reg;
        line_wdata = ring_rdata;
        case (state_reg)
            rbl_pkg::S_SINGLE:
            begin
                res_valid         = 1'b1;
                res.status        = st_reg;
                res.last          = 1'b1;
                res.line_complete = lc_reg;
                res.occupancy     = rbl_pkg::OCC_W'(count);
            end
            rbl_pkg::S_EMIT:
            begin
                res_valid         = 1'b1;
                res.status        = rbl_pkg::ST_DATA;
                res.data          = lf_pend_reg ? rbl_pkg::CH_LF : ring_rdata;
                res.last          = emit_last;
                res.occupancy     = rbl_pkg::OCC_W'(count - pops_reg);
            end
            rbl_pkg::S_LINE_EMIT:
            begin
                res_valid         = 1'b1;
                res.status        = rbl_pkg::ST_LINE_BYTE;
                res.data          = line_rdata;
                res.last          = line_last;
                res.line_complete = 1'b1;
                res.occupancy     = rbl_pkg::OCC_W'(count);
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        line_len_next   = line_len_reg;
        line_deliv_next = line_deliv_reg;
        ovw_next        = cfg_write_enable ? cfg_write_data : ovw_reg;
        lf_pend_next    = lf_pend_reg;
        sp_next         = sp_reg;
        li_next         = li_reg;
        op_next         = op_reg;
        len_next        = len_reg;
        n_next          = n_reg;
        pops_next       = pops_reg;
        ecnt_next       = ecnt_reg;
        st_next         = st_reg;
        lc_next         = lc_reg;
        case (state_reg)
            rbl_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next   = op_in;
                    len_next  = len_clamped;
                    n_next    = '0;
                    pops_next = '0;
                    lc_next   = 1'b0;
                    case (op_in)
                        rbl_pkg::OP_PUSH:
                        begin
                            if (!full)
                            begin
                                wp_next = wp_inc;
                                st_next = rbl_pkg::ST_PUSHED;
                            end
                            else if (ovw_reg)
                            begin
                                wp_next = wp_inc;
                                rp_next = rbl_pkg::ring_next(rp_reg);
                                st_next = rbl_pkg::ST_OVERWROTE;
                            end
                            else
                            begin
                                st_next = rbl_pkg::ST_DROPPED;
                            end
                        end
                        rbl_pkg::OP_RAW, rbl_pkg::OP_EXPAND:
                        begin
                            st_next = rbl_pkg::ST_NOTHING;
                        end
                        default:
                        begin
                            st_next = rbl_pkg::ST_NO_LINE;
                            if (line_deliv_reg)
                            begin
                                line_deliv_next = 1'b0;
                                line_len_next   = '0;
                            end
                        end
                    endcase
                end
            end
            rbl_pkg::S_SCAN_PRIME, rbl_pkg::S_DRAIN_PRIME:
            begin
                sp_next = rp_reg;
            end
            rbl_pkg::S_SCAN:
            begin
                // Counting pass: find how many bytes this read pops.
                sp_next   = sp_inc;
                n_next    = n_scan;
                pops_next = pops_inc;
            end
            rbl_pkg::S_EMIT_PRIME:
            begin
                sp_next      = rp_reg;
                n_next       = '0;
                ecnt_next    = '0;
                lf_pend_next = 1'b0;
            end
            rbl_pkg::S_EMIT:
            begin
                if (res_fire)
                begin
                    n_next = n_inc;
                    if (lf_pend_reg)
                    begin
                        lf_pend_next = 1'b0;
                        if (emit_last)
                        begin
                            rp_next = sp_reg;
                        end
                    end
                    else
                    begin
                        sp_next      = sp_inc;
                        ecnt_next    = ecnt_reg + 1'b1;
                        lf_pend_next = expand;
                        if (emit_last)
                        begin
                            rp_next = sp_inc;
                        end
                    end
                end
            end
            rbl_pkg::S_DRAIN:
            begin
                sp_next = sp_inc;
                if (byte_delim)
                begin
                    if (empty_after)
                    begin
                        rp_next         = sp_inc;
                        line_deliv_next = 1'b1;
                    end
                end
                else
                begin
                    // An overflowing byte is dropped and the line restarts.
                    line_len_next = line_full ? '0 : line_len_reg + 1'b1;
                    if (empty_after)
                    begin
                        rp_next = sp_inc;
                        st_next = rbl_pkg::ST_NO_LINE;
                    end
                end
            end
            rbl_pkg::S_SWALLOW:
            begin
                if (byte_delim)
                begin
                    sp_next = sp_inc;
                    if (empty_after)
                    begin
                        rp_next         = sp_inc;
                        line_deliv_next = 1'b1;
                    end
                end
                else
                begin
                    rp_next         = sp_reg;
                    line_deliv_next = 1'b1;
                end
            end
            rbl_pkg::S_LINE_PRIME:
            begin
                li_next = '0;
                st_next = rbl_pkg::ST_LINE_BYTE;
                lc_next = 1'b1;
            end
            rbl_pkg::S_LINE_EMIT:
            begin
                if (res_fire)
                begin
                    li_next = li_inc[rbl_pkg::LINE_AW-1:0];
                end
            end
            default:
            begin
                sp_next = sp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rbl_pkg::S_IDLE;
            wp_reg         <= '0;
            rp_reg         <= '0;
            line_len_reg   <= '0;
            line_deliv_reg <= 1'b0;
            ovw_reg        <= 1'b0;
            lf_pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            line_len_reg   <= line_len_next;
            line_deliv_reg <= line_deliv_next;
            ovw_reg        <= ovw_next;
            lf_pend_reg    <= lf_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sp_reg   <= sp_next;
        li_reg   <= li_next;
        op_reg   <= op_next;
        len_reg  <= len_next;
        n_reg    <= n_next;
        pops_reg <= pops_next;
        ecnt_reg <= ecnt_next;
        st_reg   <= st_next;
        lc_reg   <= lc_next;
    end

    `RBL_ASSERT_NEXT(a_push_grows, clk, rst_n, in_fire && (op_in == rbl_pkg::OP_PUSH) && !full, count == rbl_pkg::ring_ptr_t'($past(count) + 1'b1), "push into a non-full ring did not add one byte")
    `RBL_ASSERT_IMPL(a_line_byte_delivered, clk, rst_n, res_valid && (res.status == rbl_pkg::ST_LINE_BYTE), line_deliv_reg, "line byte given without a delivered line")
    `RBL_ASSERT_IMPL(a_scan_bounded, clk, rst_n, state_reg == rbl_pkg::S_SCAN, pops_reg < count, "counting pass ran past the held bytes")
    `RBL_ASSERT_IMPL(a_ring_write_idle, clk, rst_n, ring_we, state_reg == rbl_pkg::S_IDLE, "ring written outside of idle")

endmodule

>>> design/rbl_out.sv
module rbl_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  rbl_pkg::result_t res,
    output logic             res_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output rbl_pkg::result_t out_res
);

    logic             valid_reg, valid_next;
    rbl_pkg::result_t res_reg;
    logic             load;

    // The register takes a new result when empty or being emptied this cycle.
    assign res_ready  = !valid_reg || out_ready;
    assign load       = res_valid && res_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule
